[hw/rtl/sct_pkg.sv]
// Shared types and constants for the speculation checkpoint tracker.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package sct_pkg;

    localparam int DEPTH = 8;
    localparam int TAG_W = 3;
    localparam int CNT_W = 4;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RESOLVE = 2'd1;
    localparam logic [1:0] KIND_REWIND  = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic commit;
    } sct_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/speculation_checkpoint_tracker.sv]
// Top level of the speculation checkpoint tracker.
// Joins sct_ctrl and sct_datapath; types and constants come from sct_pkg.
`default_nettype none

// Tracks eight speculation checkpoints. Each item (allocate, resolve, rewind
// or query) gives exactly one result that shows the state after that item.
// An accepted item first lands in a request register and is executed once the
// output register is free, when the live bits, the dependence masks and the
// result register are updated together; a new item is taken in that same
// cycle, so the block sustains one item per clock unless a result is stalled.
// A held result under out_stall holds back execution of the following item.
// Illegal requests change nothing and return with error set.
module speculation_checkpoint_tracker
    import sct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [TAG_W-1:0]   tag,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [TAG_W-1:0]        alloc_tag,
    output logic [DEPTH-1:0]        in_use_mask,
    output logic [CNT_W-1:0]        live_count,
    output logic                    has_free,
    output logic                    oldest_valid,
    output logic [TAG_W-1:0]        oldest_tag,
    output logic                    error
);

    sct_cmd_t cmd;

    sct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sct_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .tag          (tag),
        .alloc_tag    (alloc_tag),
        .in_use_mask  (in_use_mask),
        .live_count   (live_count),
        .has_free     (has_free),
        .oldest_valid (oldest_valid),
        .oldest_tag   (oldest_tag),
        .error        (error)
    );

endmodule

`default_nettype wire

[hw/rtl/sct_ctrl.sv]
// Controller of the checkpoint tracker: input and output handshakes.
// Depends on sct_pkg for the command struct.
`default_nettype none

module sct_ctrl
    import sct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output sct_cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   exec_go;
    logic   in_ready;
    logic   accept;

    // An item held in the request register executes once the output register is free.
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign in_ready = (state_reg == ST_IDLE) || exec_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall     = !in_ready;
    assign out_valid    = out_valid_reg;
    assign cmd.load_req = accept;
    assign cmd.commit   = exec_go;

endmodule

`default_nettype wire

[hw/rtl/sct_datapath.sv]
// Datapath of the checkpoint tracker: request register, live bits, dependence
// masks, next-state logic and result register. Depends on sct_pkg.
`default_nettype none

module sct_datapath
    import sct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sct_cmd_t           cmd,
    input  wire logic [1:0]         kind,
    input  wire logic [TAG_W-1:0]   tag,
    output logic [TAG_W-1:0]        alloc_tag,
    output logic [DEPTH-1:0]        in_use_mask,
    output logic [CNT_W-1:0]        live_count,
    output logic                    has_free,
    output logic                    oldest_valid,
    output logic [TAG_W-1:0]        oldest_tag,
    output logic                    error
);

    logic [1:0]       req_kind_reg;
    logic [TAG_W-1:0] req_tag_reg;
    logic [DEPTH-1:0] live_reg;
    logic [DEPTH-1:0] live_next;
    logic [CNT_W-1:0] live_total_reg;
    logic [CNT_W-1:0] live_total_next;
    logic [DEPTH-1:0] dep_reg  [DEPTH];
    logic [DEPTH-1:0] dep_next [DEPTH];

    logic [TAG_W-1:0] alloc_tag_reg;
    logic [TAG_W-1:0] alloc_tag_next;
    logic [DEPTH-1:0] mask_reg;
    logic [CNT_W-1:0] count_reg;
    logic             has_free_reg;
    logic             has_free_next;
    logic             oldest_valid_reg;
    logic             oldest_valid_next;
    logic [TAG_W-1:0] oldest_tag_reg;
    logic [TAG_W-1:0] oldest_tag_next;
    logic             error_reg;
    logic             error_next;

    logic [TAG_W-1:0] free_idx;
    logic             full;
    logic             tag_live;
    logic [DEPTH-1:0] tag_bit;
    logic [DEPTH-1:0] kill;

    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_idx = TAG_W'(i);
            end
        end

        full     = (live_total_reg == CNT_W'(DEPTH));
        tag_live = live_reg[req_tag_reg];
        tag_bit  = DEPTH'(1) << req_tag_reg;

        // A rewind also kills every live checkpoint that was taken under the tag.
        kill = tag_bit;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (live_reg[i] && dep_reg[i][req_tag_reg])
            begin
                kill[i] = 1'b1;
            end
        end

        live_next      = live_reg;
        dep_next       = dep_reg;
        error_next     = 1'b0;
        alloc_tag_next = '0;

        case (req_kind_reg)
            KIND_ALLOC:
            begin
                if (full)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    dep_next[free_idx]  = live_reg;
                    live_next[free_idx] = 1'b1;
                    alloc_tag_next      = free_idx;
                end
            end
            KIND_RESOLVE:
            begin
                if (!tag_live)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    live_next = live_reg & ~tag_bit;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        dep_next[i] = dep_reg[i] & ~tag_bit;
                    end
                end
            end
            KIND_REWIND:
            begin
                if (!tag_live)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    live_next = live_reg & ~kill;
                end
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase

        live_total_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            live_total_next = live_total_next + CNT_W'(live_next[i]);
        end
        has_free_next = (live_total_next != CNT_W'(DEPTH));

        // The oldest checkpoint is the lowest live tag with no dependences left.
        oldest_valid_next = 1'b0;
        oldest_tag_next   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (live_next[i] && (dep_next[i] == '0))
            begin
                oldest_valid_next = 1'b1;
                oldest_tag_next   = TAG_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            live_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            live_reg       <= live_next;
            live_total_reg <= live_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_kind_reg <= kind;
            req_tag_reg  <= tag;
        end
        if (cmd.commit)
        begin
            dep_reg          <= dep_next;
            alloc_tag_reg    <= alloc_tag_next;
            mask_reg         <= live_next;
            count_reg        <= live_total_next;
            has_free_reg     <= has_free_next;
            oldest_valid_reg <= oldest_valid_next;
            oldest_tag_reg   <= oldest_tag_next;
            error_reg        <= error_next;
        end
    end

    assign alloc_tag    = alloc_tag_reg;
    assign in_use_mask  = mask_reg;
    assign live_count   = count_reg;
    assign has_free     = has_free_reg;
    assign oldest_valid = oldest_valid_reg;
    assign oldest_tag   = oldest_tag_reg;
    assign error        = error_reg;

endmodule

`default_nettype wire

[hw/rtl/sct_checker.sv]
// Port-level checks for the speculation checkpoint tracker, bound to the top level.
// Depends on sct_pkg for widths.
`default_nettype none

module sct_checker
    import sct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [TAG_W-1:0]   alloc_tag,
    input  wire logic [DEPTH-1:0]   in_use_mask,
    input  wire logic [CNT_W-1:0]   live_count,
    input  wire logic               has_free,
    input  wire logic               oldest_valid,
    input  wire logic [TAG_W-1:0]   oldest_tag,
    input  wire logic               error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(in_use_mask)
            && $stable(live_count) && $stable(error) && $stable(alloc_tag))
        else $error("result changed while stalled");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> live_count == CNT_W'($countones(in_use_mask)))
        else $error("live count does not match in-use mask");

    a_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> has_free == (live_count != CNT_W'(DEPTH)))
        else $error("has_free disagrees with live count");

    a_error_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> alloc_tag == '0)
        else $error("tag given out on an illegal request");

    a_oldest_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oldest_valid |-> in_use_mask[oldest_tag])
        else $error("oldest checkpoint is not live");

endmodule

bind speculation_checkpoint_tracker sct_checker u_sct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alloc_tag    (alloc_tag),
    .in_use_mask  (in_use_mask),
    .live_count   (live_count),
    .has_free     (has_free),
    .oldest_valid (oldest_valid),
    .oldest_tag   (oldest_tag),
    .error        (error)
);

`default_nettype wire

[dv/tb_speculation_checkpoint_tracker.sv]
// Self-checking testbench for speculation_checkpoint_tracker: a directed table of items,
// then constrained-by-hand random item sequences, checked against table values or a local predictor.
// Depends on sct_pkg for DEPTH, the field widths and the item kind codes.
`default_nettype none

module tb_speculation_checkpoint_tracker;
    import sct_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT     = 12;

    typedef struct packed {
        logic [TAG_W-1:0] alloc_tag;
        logic [DEPTH-1:0] mask;
        logic [CNT_W-1:0] count;
        logic             has_free;
        logic             oldest_valid;
        logic [TAG_W-1:0] oldest_tag;
        logic             error;
    } ckpt_result_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [TAG_W-1:0] tg;
        logic             known;
        ckpt_result_t     want;
    } plan_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             out_stall = 1'b0;
    logic [1:0]       kind      = KIND_QUERY;
    logic [TAG_W-1:0] tag       = '0;
    logic             in_stall;
    logic             out_valid;
    logic [TAG_W-1:0] alloc_tag;
    logic [DEPTH-1:0] in_use_mask;
    logic [CNT_W-1:0] live_count;
    logic             has_free;
    logic             oldest_valid;
    logic [TAG_W-1:0] oldest_tag;
    logic             error;

    // Predictor state: the live set and one dependence mask per tag.
    logic [DEPTH-1:0] live;
    logic [DEPTH-1:0] deps [DEPTH];

    plan_row_t    plan [$];
    ckpt_result_t pending_results [$];
    ckpt_result_t head;
    ckpt_result_t pred;
    ckpt_result_t cur_want;
    logic         cur_known;
    int           plan_idx    = 0;
    int           sent        = 0;
    int           total_items = 0;
    int           checked     = 0;
    int           fail_count  = 0;
    int           cycle_count = 0;
    int           n_alloc = 0, n_resolve = 0, n_rewind = 0, n_query = 0;
    int           n_refused = 0, n_full_alloc = 0;
    logic         calm;

    speculation_checkpoint_tracker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .alloc_tag    (alloc_tag),
        .in_use_mask  (in_use_mask),
        .live_count   (live_count),
        .has_free     (has_free),
        .oldest_valid (oldest_valid),
        .oldest_tag   (oldest_tag),
        .error        (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A long stretch in the middle of the run with neither side idling.
    assign calm = (sent >= 150) && (sent < 260);

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Applies one item to the predictor state and returns the result it must produce.
    function automatic ckpt_result_t track_checkpoint(input logic [1:0] op,
                                                      input logic [TAG_W-1:0] tg);
        ckpt_result_t     r;
        logic [DEPTH-1:0] bit_sel;
        logic [DEPTH-1:0] doomed;
        int               slot;
        r = '0;
        bit_sel = '0;
        bit_sel[tg] = 1'b1;
        slot = -1;
        case (op)
            KIND_ALLOC:
            begin
                n_alloc++;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!live[i])
                        slot = i;
                if (slot < 0)
                begin
                    r.error = 1'b1;
                    n_full_alloc++;
                end
                else
                begin
                    deps[slot] = live;
                    live[slot] = 1'b1;
                    r.alloc_tag = slot[TAG_W-1:0];
                end
            end
            KIND_RESOLVE:
            begin
                n_resolve++;
                if (!live[tg])
                    r.error = 1'b1;
                else
                begin
                    live[tg] = 1'b0;
                    for (int i = 0; i < DEPTH; i++)
                        deps[i] = deps[i] & ~bit_sel;
                end
            end
            KIND_REWIND:
            begin
                n_rewind++;
                if (!live[tg])
                    r.error = 1'b1;
                else
                begin
                    doomed = bit_sel;
                    for (int i = 0; i < DEPTH; i++)
                        if (live[i] && ((deps[i] & bit_sel) != '0))
                            doomed[i] = 1'b1;
                    live = live & ~doomed;
                end
            end
            default:
                n_query++;
        endcase
        if (r.error)
            n_refused++;
        r.mask = live;
        r.count = CNT_W'($countones(live));
        r.has_free = (r.count < DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (live[i] && (deps[i] == '0))
            begin
                r.oldest_valid = 1'b1;
                r.oldest_tag = i[TAG_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] pick_live_tag();
        int               start;
        int               idx;
        logic [TAG_W-1:0] t;
        start = $urandom_range(0, DEPTH - 1);
        t = start[TAG_W-1:0];
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            idx = (start + k) % DEPTH;
            if (live[idx])
                t = idx[TAG_W-1:0];
        end
        return t;
    endfunction

    // Mostly legal requests on live tags; the rest hit dead tags or a full table.
    task automatic choose_item(output logic [1:0] op, output logic [TAG_W-1:0] tg);
        int roll;
        roll = $urandom_range(0, 99);
        tg = TAG_W'($urandom_range(0, DEPTH - 1));
        if (live == '0)
        begin
            if (roll < 75)
                op = KIND_ALLOC;
            else if (roll < 85)
                op = KIND_QUERY;
            else if (roll < 93)
                op = KIND_RESOLVE;
            else
                op = KIND_REWIND;
        end
        else if (roll < 42)
            op = KIND_ALLOC;
        else if (roll < 66)
        begin
            op = KIND_RESOLVE;
            tg = pick_live_tag();
        end
        else if (roll < 84)
        begin
            op = KIND_REWIND;
            tg = pick_live_tag();
        end
        else if (roll < 90)
            op = KIND_QUERY;
        else
            op = (roll % 2 == 0) ? KIND_RESOLVE : KIND_REWIND;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [TAG_W-1:0] tg,
                           input logic known, input logic [TAG_W-1:0] a_tag,
                           input logic [DEPTH-1:0] mask, input logic [CNT_W-1:0] cnt,
                           input logic free, input logic ov, input logic [TAG_W-1:0] ot,
                           input logic err);
        plan_row_t row;
        row.op                = op;
        row.tg                = tg;
        row.known             = known;
        row.want.alloc_tag    = a_tag;
        row.want.mask         = mask;
        row.want.count        = cnt;
        row.want.has_free     = free;
        row.want.oldest_valid = ov;
        row.want.oldest_tag   = ot;
        row.want.error        = err;
        plan.push_back(row);
    endtask

    task automatic present_next();
        logic [1:0]       op;
        logic [TAG_W-1:0] tg;
        if (!calm && ($urandom_range(0, 99) < IDLE_PCT))
            in_valid <= 1'b0;
        else
        begin
            if (plan_idx < plan.size())
            begin
                op = plan[plan_idx].op;
                tg = plan[plan_idx].tg;
                cur_known = plan[plan_idx].known;
                cur_want = plan[plan_idx].want;
                plan_idx++;
            end
            else
            begin
                choose_item(op, tg);
                cur_known = 1'b0;
            end
            in_valid <= 1'b1;
            kind <= op;
            tag <= tg;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result: mask=%02h count=%0d error=%0b",
                             in_use_mask, live_count, error);
                fail_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (head.alloc_tag !== alloc_tag || head.mask !== in_use_mask ||
                    head.count !== live_count || head.has_free !== has_free ||
                    head.oldest_valid !== oldest_valid || head.oldest_tag !== oldest_tag ||
                    head.error !== error)
                begin
                    if (fail_count < 10)
                    begin
                        $write("result %0d expected: tag=%0d mask=%02h cnt=%0d ",
                               checked, head.alloc_tag, head.mask, head.count);
                        $display("free=%0b old=%0b/%0d err=%0b",
                                 head.has_free, head.oldest_valid, head.oldest_tag,
                                 head.error);
                        $write("result %0d actual:   tag=%0d mask=%02h cnt=%0d ",
                               checked, alloc_tag, in_use_mask, live_count);
                        $display("free=%0b old=%0b/%0d err=%0b",
                                 has_free, oldest_valid, oldest_tag, error);
                    end
                    fail_count++;
                end
                checked++;
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("** speculation_checkpoint_tracker: FAILED **");
        $finish;
    end

    initial
    begin
        live = '0;
        for (int i = 0; i < DEPTH; i++)
            deps[i] = '0;

        // Empty table: query, then resolve and rewind of tags that are not live.
        add_row(KIND_QUERY,   3'd0, 1'b1, 3'd0, 8'h00, 4'd0, 1'b1, 1'b0, 3'd0, 1'b0);
        add_row(KIND_RESOLVE, 3'd0, 1'b1, 3'd0, 8'h00, 4'd0, 1'b1, 1'b0, 3'd0, 1'b1);
        add_row(KIND_REWIND,  3'd7, 1'b1, 3'd0, 8'h00, 4'd0, 1'b1, 1'b0, 3'd0, 1'b1);
        // Fill every tag in order; tag 0 stays the oldest throughout.
        for (int i = 0; i < DEPTH; i++)
            add_row(KIND_ALLOC, 3'd5, 1'b1, i[TAG_W-1:0], DEPTH'((2 << i) - 1),
                    CNT_W'(i + 1), i < DEPTH - 1, 1'b1, 3'd0, 1'b0);
        add_row(KIND_ALLOC,   3'd2, 1'b1, 3'd0, 8'hff, 4'd8, 1'b0, 1'b1, 3'd0, 1'b1);
        add_row(KIND_QUERY,   3'd5, 1'b1, 3'd0, 8'hff, 4'd8, 1'b0, 1'b1, 3'd0, 1'b0);
        add_row(KIND_RESOLVE, 3'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_REWIND,  3'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_REWIND,  3'd3, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_RESOLVE, 3'd3, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_REWIND,  3'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        // Reused low tags now depend on younger-numbered live checkpoints.
        add_row(KIND_ALLOC,   3'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_ALLOC,   3'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_RESOLVE, 3'd2, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_REWIND,  3'd1, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_QUERY,   3'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_ALLOC,   3'd1, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        add_row(KIND_REWIND,  3'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
        total_items = plan.size() + RANDOM_ITEMS;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        present_next();
        while (sent < total_items)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                pred = track_checkpoint(kind, tag);
                pending_results.push_back(cur_known ? cur_want : pred);
                sent++;
                if (sent < total_items)
                    present_next();
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid)
                present_next();
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items: %0d allocate, %0d resolve, %0d rewind, %0d query",
                 sent, n_alloc, n_resolve, n_rewind, n_query);
        $display("%0d refused requests (%0d allocates on a full table), %0d results checked",
                 n_refused, n_full_alloc, checked);
        if (fail_count == 0)
            $display("** speculation_checkpoint_tracker: PASSED **");
        else
            $display("** speculation_checkpoint_tracker: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/sct_pkg.sv
hw/rtl/sct_ctrl.sv
hw/rtl/sct_datapath.sv
hw/rtl/speculation_checkpoint_tracker.sv
hw/rtl/sct_checker.sv
dv/tb_speculation_checkpoint_tracker.sv
